FILE: design/rcswap_pkg.sv
package rcswap_pkg;

   localparam int ACTION_W     = 2;
   localparam int INDEX_W      = 13;
   localparam int VALUE_W      = 23;
   localparam int ROW_W        = 11;
   localparam int COL_W        = 13;
   localparam int ROWS_DEFAULT = 1024;
   localparam int COLS_DEFAULT = 4096;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SWAP_ROWS  = 2'd0,
      ACT_SWAP_COLS  = 2'd1,
      ACT_VALUE_AT   = 2'd2,
      ACT_FIND_VALUE = 2'd3
   } action_type;

   typedef struct packed {
      logic clr_wr;
      logic fwd_rd;
      logic lat;
      logic swap_wr;
      logic wr_b;
      logic inv_rd;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic       clr_done;
      logic       req_err;
      logic       out_free;
      action_type req_action;
   } status_type;

endpackage

FILE: design/rcswap_ifs.sv
interface rcswap_req_if import rcswap_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ACTION_W-1:0] action;
   logic [INDEX_W-1:0]  first_index;
   logic [INDEX_W-1:0]  second_index;
   logic [VALUE_W-1:0]  cell_value;

   modport source (output valid, action, first_index, second_index, cell_value,
                   input ready);
   modport sink   (input valid, action, first_index, second_index, cell_value,
                   output ready);
endinterface

interface rcswap_rsp_if import rcswap_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] found_value;
   logic [ROW_W-1:0]   found_row;
   logic [COL_W-1:0]   found_column;
   logic               out_of_range;

   modport source (output valid, found_value, found_row, found_column, out_of_range,
                   input ready);
   modport sink   (input valid, found_value, found_row, found_column, out_of_range,
                   output ready);
endinterface

FILE: design/rcswap_cdiv.sv
module rcswap_cdiv import rcswap_pkg::*; #(
   parameter int COLS = COLS_DEFAULT
) (
   input  logic                              clock,
   input  logic [VALUE_W-1:0]                dividend,
   output logic [VALUE_W-1:0]                quot,
   output logic [$clog2(COLS+1)-1:0]         rem
);

   localparam int CAW     = $clog2(COLS + 1);
   localparam int SHIFT   = VALUE_W + CAW;
   localparam int RECIP_W = VALUE_W + 2;
   localparam int PROD1_W = VALUE_W + RECIP_W;
   localparam int QC_W    = VALUE_W + CAW;
   localparam int REM_W   = CAW + 1;
   localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / COLS;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

   logic [VALUE_W-1:0] x1_ff, x2_ff;
   logic [PROD1_W-1:0] prod1_ff;
   logic [VALUE_W-1:0] q_est;
   logic [VALUE_W-1:0] q2_ff;
   logic [QC_W-1:0]    qc_ff;
   logic [QC_W-1:0]    diff;
   logic [REM_W-1:0]   rem_pre;
   logic [VALUE_W-1:0] quot_in, quot_ff;
   logic [CAW-1:0]     rem_in, rem_ff;

   // estimate from a floored reciprocal is low by at most one
   assign q_est = VALUE_W'(prod1_ff >> SHIFT);

   always_comb begin
      diff    = QC_W'(x2_ff) - qc_ff;
      rem_pre = REM_W'(diff);
      if (rem_pre >= REM_W'(COLS)) begin
         rem_in  = CAW'(rem_pre - REM_W'(COLS));
         quot_in = q2_ff + VALUE_W'(1);
      end else begin
         rem_in  = CAW'(rem_pre);
         quot_in = q2_ff;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff    <= dividend;
      prod1_ff <= PROD1_W'(dividend) * PROD1_W'(RECIP);
      x2_ff    <= x1_ff;
      q2_ff    <= q_est;
      qc_ff    <= QC_W'(q_est) * QC_W'(COLS);
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
   end

   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule

FILE: design/rcswap_dpath.sv
module rcswap_dpath import rcswap_pkg::*; #(
   parameter int ROWS = ROWS_DEFAULT,
   parameter int COLS = COLS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [ACTION_W-1:0] action,
   input  logic [INDEX_W-1:0]  first_index,
   input  logic [INDEX_W-1:0]  second_index,
   input  logic [VALUE_W-1:0]  cell_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [VALUE_W-1:0]  found_value,
   output logic [ROW_W-1:0]    found_row,
   output logic [COL_W-1:0]    found_column,
   output logic                out_of_range
);

   localparam int RAW    = $clog2(ROWS + 1);
   localparam int CAW    = $clog2(COLS + 1);
   localparam int PROD_W = RAW + CAW;
   localparam int MAXN   = (ROWS > COLS) ? ROWS : COLS;
   localparam int CLR_W  = $clog2(MAXN + 1);
   localparam int LIM_W  = INDEX_W + 1;
   localparam int VLIM_W = VALUE_W + 3;
   localparam logic [LIM_W-1:0]  ROW_LIM = LIM_W'(ROWS);
   localparam logic [LIM_W-1:0]  COL_LIM = LIM_W'(COLS);
   localparam logic [VLIM_W-1:0] VAL_LIM = VLIM_W'(ROWS * COLS);

   logic [RAW-1:0] row_fwd_mem [ROWS+1];
   logic [RAW-1:0] row_inv_mem [ROWS+1];
   logic [CAW-1:0] col_fwd_mem [COLS+1];
   logic [CAW-1:0] col_inv_mem [COLS+1];

   logic [CLR_W-1:0]   clr_idx_ff, clr_idx_in;
   action_type         act_ff;
   logic               err_ff;
   logic [INDEX_W-1:0] a_ff, b_ff;
   logic [VALUE_W-1:0] x_ff;

   logic [RAW-1:0] row_rd0_ff, row_rd1_ff, row_inv_rd_ff;
   logic [CAW-1:0] col_rd0_ff, col_rd1_ff, col_inv_rd_ff;
   logic [PROD_W-1:0] prod_ff;

   logic [VALUE_W-1:0] quot;
   logic [CAW-1:0]     rem;

   logic           row_we, col_we;
   logic [RAW-1:0] row_fwd_wa, row_fwd_wd, row_inv_wa, row_inv_wd;
   logic [CAW-1:0] col_fwd_wa, col_fwd_wd, col_inv_wa, col_inv_wd;
   logic [RAW-1:0] row_inv_ra;
   logic [CAW-1:0] col_inv_ra;

   logic row_ok_a, row_ok_b, col_ok_a, col_ok_b, val_ok;
   logic req_err;
   action_type req_act;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] found_value_ff, found_value_in;
   logic [ROW_W-1:0]   found_row_ff, found_row_in;
   logic [COL_W-1:0]   found_column_ff, found_column_in;
   logic               out_of_range_ff, out_of_range_in;

   // range checks on the incoming beat
   always_comb begin
      req_act  = action_type'(action);
      row_ok_a = (first_index != '0) && (LIM_W'(first_index) <= ROW_LIM);
      row_ok_b = (second_index != '0) && (LIM_W'(second_index) <= ROW_LIM);
      col_ok_a = (first_index != '0) && (LIM_W'(first_index) <= COL_LIM);
      col_ok_b = (second_index != '0) && (LIM_W'(second_index) <= COL_LIM);
      val_ok   = (cell_value != '0) && (VLIM_W'(cell_value) <= VAL_LIM);
      case (req_act)
         ACT_SWAP_ROWS: req_err = !(row_ok_a && row_ok_b);
         ACT_SWAP_COLS: req_err = !(col_ok_a && col_ok_b);
         ACT_VALUE_AT:  req_err = !(row_ok_a && col_ok_b);
         default:       req_err = !val_ok;
      endcase
   end

   assign status.clr_done   = (clr_idx_ff == CLR_W'(MAXN));
   assign status.req_err    = req_err;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.req_action = req_act;

   assign clr_idx_in = cmd.clr_wr ? clr_idx_ff + CLR_W'(1) : clr_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else begin
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lat) begin
         act_ff <= req_act;
         err_ff <= req_err;
         a_ff   <= first_index;
         b_ff   <= second_index;
         x_ff   <= cell_value - VALUE_W'(1);
      end
   end

   // write ports: identity fill, then swap beats A and B
   always_comb begin
      row_we     = 1'b0;
      col_we     = 1'b0;
      row_fwd_wa = RAW'(clr_idx_ff);
      row_fwd_wd = RAW'(clr_idx_ff);
      row_inv_wa = RAW'(clr_idx_ff);
      row_inv_wd = RAW'(clr_idx_ff);
      col_fwd_wa = CAW'(clr_idx_ff);
      col_fwd_wd = CAW'(clr_idx_ff);
      col_inv_wa = CAW'(clr_idx_ff);
      col_inv_wd = CAW'(clr_idx_ff);
      if (cmd.clr_wr) begin
         row_we = (clr_idx_ff <= CLR_W'(ROWS));
         col_we = (clr_idx_ff <= CLR_W'(COLS));
      end else if (cmd.swap_wr) begin
         row_we = (act_ff == ACT_SWAP_ROWS);
         col_we = (act_ff == ACT_SWAP_COLS);
         if (!cmd.wr_b) begin
            row_fwd_wa = RAW'(a_ff);
            row_fwd_wd = row_rd1_ff;
            row_inv_wa = row_rd1_ff;
            row_inv_wd = RAW'(a_ff);
            col_fwd_wa = CAW'(a_ff);
            col_fwd_wd = col_rd1_ff;
            col_inv_wa = col_rd1_ff;
            col_inv_wd = CAW'(a_ff);
         end else begin
            row_fwd_wa = RAW'(b_ff);
            row_fwd_wd = row_rd0_ff;
            row_inv_wa = row_rd0_ff;
            row_inv_wd = RAW'(b_ff);
            col_fwd_wa = CAW'(b_ff);
            col_fwd_wd = col_rd0_ff;
            col_inv_wa = col_rd0_ff;
            col_inv_wd = CAW'(b_ff);
         end
      end
   end

   assign row_inv_ra = RAW'(quot) + RAW'(1);
   assign col_inv_ra = rem + CAW'(1);

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_fwd_mem[row_fwd_wa] <= row_fwd_wd;
      end
      if (cmd.fwd_rd) begin
         row_rd0_ff <= row_fwd_mem[RAW'(first_index)];
         row_rd1_ff <= row_fwd_mem[RAW'(second_index)];
      end
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_inv_mem[row_inv_wa] <= row_inv_wd;
      end
      if (cmd.inv_rd) begin
         row_inv_rd_ff <= row_inv_mem[row_inv_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_fwd_mem[col_fwd_wa] <= col_fwd_wd;
      end
      if (cmd.fwd_rd) begin
         col_rd0_ff <= col_fwd_mem[CAW'(first_index)];
         col_rd1_ff <= col_fwd_mem[CAW'(second_index)];
      end
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         col_inv_mem[col_inv_wa] <= col_inv_wd;
      end
      if (cmd.inv_rd) begin
         col_inv_rd_ff <= col_inv_mem[col_inv_ra];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(row_rd0_ff - RAW'(1)) * PROD_W'(COLS);
   end

   rcswap_cdiv #(
      .COLS (COLS)
   ) u_cdiv (
      .clock    (clock),
      .dividend (x_ff),
      .quot     (quot),
      .rem      (rem)
   );

   // result register
   always_comb begin
      found_value_in  = '0;
      found_row_in    = '0;
      found_column_in = '0;
      out_of_range_in = 1'b0;
      if (err_ff) begin
         out_of_range_in = 1'b1;
      end else if (act_ff == ACT_VALUE_AT) begin
         found_value_in = VALUE_W'(prod_ff + PROD_W'(col_rd1_ff));
      end else begin
         found_row_in    = ROW_W'(row_inv_rd_ff);
         found_column_in = COL_W'(col_inv_rd_ff);
      end
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         found_value_ff  <= found_value_in;
         found_row_ff    <= found_row_in;
         found_column_ff <= found_column_in;
         out_of_range_ff <= out_of_range_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign found_value  = found_value_ff;
   assign found_row    = found_row_ff;
   assign found_column = found_column_ff;
   assign out_of_range = out_of_range_ff;

endmodule

FILE: design/rcswap_ctrl.sv
module rcswap_ctrl import rcswap_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SWAP_A,
      ST_SWAP_B,
      ST_MUL,
      ST_DIV1,
      ST_DIV2,
      ST_DIV3,
      ST_INV_RD,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.fwd_rd = 1'b1;
            if (req_valid) begin
               cmd.lat = 1'b1;
               if (status.req_err) begin
                  state_in = ST_EMIT;
               end else begin
                  case (status.req_action)
                     ACT_SWAP_ROWS: state_in = ST_SWAP_A;
                     ACT_SWAP_COLS: state_in = ST_SWAP_A;
                     ACT_VALUE_AT:  state_in = ST_MUL;
                     default:       state_in = ST_DIV1;
                  endcase
               end
            end
         end
         ST_SWAP_A: begin
            cmd.swap_wr = 1'b1;
            state_in    = ST_SWAP_B;
         end
         ST_SWAP_B: begin
            cmd.swap_wr = 1'b1;
            cmd.wr_b    = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_MUL:  state_in = ST_EMIT;
         ST_DIV1: state_in = ST_DIV2;
         ST_DIV2: state_in = ST_DIV3;
         ST_DIV3: state_in = ST_INV_RD;
         ST_INV_RD: begin
            cmd.inv_rd = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

FILE: design/row_column_swap_remap_table_top.sv
// Row and column permutation of a ROWS x COLS grid whose cell at original row r,
// column c holds (r-1)*COLS+c, with forward and inverse maps for both axes held in
// on-chip memories. After reset the maps are filled with the identity, one entry
// per cycle, as a counter runs from 0 to max(ROWS,COLS); no request beat is taken
// meanwhile. Items are handled one at a time. A row or column swap gives no
// response: two forward entries are read together, then each map's single write
// port takes one forward and one inverse entry per cycle. A value query does a
// map read, a multiply by COLS and an add. A position query passes through the
// 3-stage reciprocal divider by COLS and then the inverse-map read.
// A request out of range is answered with out_of_range set and the maps untouched.
// A finished response waits in an output register, and the next request beat is
// accepted while it waits.
module row_column_swap_remap_table_top import rcswap_pkg::*; #(
   parameter int ROWS = ROWS_DEFAULT,
   parameter int COLS = COLS_DEFAULT
) (
   input logic           clock,
   input logic           reset,
   rcswap_req_if.sink    req_chan,
   rcswap_rsp_if.source  rsp_chan
);

   cmd_type    cmd;
   status_type status;

   rcswap_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rcswap_dpath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .action       (req_chan.action),
      .first_index  (req_chan.first_index),
      .second_index (req_chan.second_index),
      .cell_value   (req_chan.cell_value),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .found_value  (rsp_chan.found_value),
      .found_row    (rsp_chan.found_row),
      .found_column (rsp_chan.found_column),
      .out_of_range (rsp_chan.out_of_range)
   );

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("response loaded over an untaken beat");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while an item is in progress");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      cmd.clr_wr |-> (!req_chan.ready && !rsp_chan.valid))
      else $error("traffic during map fill");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.out_of_range) |->
         (rsp_chan.found_value == '0 && rsp_chan.found_row == '0 &&
          rsp_chan.found_column == '0))
      else $error("error response carries data");

endmodule
